@@ design/depth_pixel_back_projection_macros.svh @@
// Assertion macros used by the checker of the depth pixel back-projection block.
// Depends on nothing; the checker file takes it in by include.
`ifndef DEPTH_PIXEL_BACK_PROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPBP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dpbp_pkg.sv @@
// Package of the depth pixel back-projection block: widths, register map and payload types.
// Used by the top level and by its checker; depends on nothing.
package dpbp_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEPTH_W    = 16;
  localparam int CFG_W      = 20;
  localparam int SCALE_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = 32;
  localparam int DIV_STEPS  = Q_W;
  localparam int POS_W      = COORD_BITS + 8;
  localparam int MAG_W      = (POS_W > CFG_W) ? POS_W : CFG_W;
  localparam int PROD_W     = MAG_W + DEPTH_W;
  localparam int DEN_W      = SCALE_W + CFG_W;

  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FOCAL_X     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd4;

  localparam logic [CFG_W-1:0]   FOCAL_X_RST     = 20'd132710;
  localparam logic [CFG_W-1:0]   FOCAL_Y_RST     = 20'd132710;
  localparam logic [CFG_W-1:0]   CENTER_X_RST    = 20'd83328;
  localparam logic [CFG_W-1:0]   CENTER_Y_RST    = 20'd64896;
  localparam logic [SCALE_W-1:0] DEPTH_SCALE_RST = 16'd1000;

  localparam logic [Q_W-1:0]   Q_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0]   Q_NEG_MIN = 32'h8000_0000;
  localparam logic [Q_W-2:0]   Z_MAX     = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [DEPTH_W-1:0]    depth_raw;
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COLOR_W-1:0]    blue_in;
    logic [COLOR_W-1:0]    green_in;
    logic [COLOR_W-1:0]    red_in;
  } dpbp_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] point_x;
    logic signed [Q_W-1:0] point_y;
    logic [Q_W-2:0]        point_z;
    logic [COLOR_W-1:0]    blue_out;
    logic [COLOR_W-1:0]    green_out;
    logic [COLOR_W-1:0]    red_out;
  } dpbp_out_t;

endpackage

@@ design/depth_pixel_back_projection.sv @@
// Top level of the depth pixel back-projection block: register file and pixel pipeline.
// Depends on dpbp_pkg for widths, the register map and the request types.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_stall      dpbp_in_t (depth, row, column, color)
//   out_     output     out_valid / out_stall    dpbp_out_t (x, y, z, color)
//   cfg      APB write  psel/penable/pwrite      five registers at byte addresses 4*i
//
// One request is taken every cycle unless a stalled result waits at the output.
// Three long dividers of 32 one-bit stages follow the offset and product registers.
// A request with zero depth passes as a bubble and gives no result.
// Reset is synchronous; it clears the valid bits and loads the register defaults.
// A stalled result holds the whole pipeline, and no request is dropped or repeated.
module depth_pixel_back_projection (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  dpbp_pkg::dpbp_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output dpbp_pkg::dpbp_out_t       out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dpbp_pkg::ADDR_W-1:0] paddr,
  input  logic [dpbp_pkg::DATA_W-1:0] pwdata,
  output logic [dpbp_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import dpbp_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } color_t;

  typedef struct packed {
    logic               valid;
    logic [DEPTH_W-1:0] depth;
    logic [MAG_W-1:0]   mag_x;
    logic               neg_x;
    logic [MAG_W-1:0]   mag_y;
    logic               neg_y;
    color_t             color;
  } mag_stage_t;

  typedef struct packed {
    logic               valid;
    logic [DEPTH_W-1:0] depth;
    logic [PROD_W-1:0]  prod_x;
    logic               neg_x;
    logic [PROD_W-1:0]  prod_y;
    logic               neg_y;
    color_t             color;
  } prod_stage_t;

  typedef struct packed {
    logic               valid;
    logic [DEN_W-1:0]   rem_x;
    logic [Q_W-1:0]     word_x;
    logic               neg_x;
    logic               ovf_x;
    logic [DEN_W-1:0]   rem_y;
    logic [Q_W-1:0]     word_y;
    logic               neg_y;
    logic               ovf_y;
    logic [SCALE_W-1:0] rem_z;
    logic [Q_W-1:0]     word_z;
    color_t             color;
  } div_stage_t;

  // Register file.
  logic [CFG_W-1:0]   focal_x_r;
  logic [CFG_W-1:0]   focal_y_r;
  logic [CFG_W-1:0]   center_x_r;
  logic [CFG_W-1:0]   center_y_r;
  logic [SCALE_W-1:0] depth_scale_r;
  logic [DEN_W-1:0]   den_x_r;
  logic [DEN_W-1:0]   den_y_r;
  logic [SCALE_W-1:0] scale_eff_r;
  logic [DEN_W-1:0]   den_x_nxt;
  logic [DEN_W-1:0]   den_y_nxt;
  logic [SCALE_W-1:0] scale_eff_nxt;
  logic [CFG_W-1:0]   focal_x_eff;
  logic [CFG_W-1:0]   focal_y_eff;
  logic               cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r     <= FOCAL_X_RST;
      focal_y_r     <= FOCAL_Y_RST;
      center_x_r    <= CENTER_X_RST;
      center_y_r    <= CENTER_Y_RST;
      depth_scale_r <= DEPTH_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FOCAL_X:     focal_x_r     <= pwdata[CFG_W-1:0];
        REG_FOCAL_Y:     focal_y_r     <= pwdata[CFG_W-1:0];
        REG_CENTER_X:    center_x_r    <= pwdata[CFG_W-1:0];
        REG_CENTER_Y:    center_y_r    <= pwdata[CFG_W-1:0];
        REG_DEPTH_SCALE: depth_scale_r <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FOCAL_X:     prdata = DATA_W'(focal_x_r);
      REG_FOCAL_Y:     prdata = DATA_W'(focal_y_r);
      REG_CENTER_X:    prdata = DATA_W'(center_x_r);
      REG_CENTER_Y:    prdata = DATA_W'(center_y_r);
      REG_DEPTH_SCALE: prdata = DATA_W'(depth_scale_r);
      default:         prdata = '0;
    endcase
  end

  // A zero divisor register acts as one.
  assign scale_eff_nxt = (depth_scale_r == '0) ? SCALE_W'(1) : depth_scale_r;
  assign focal_x_eff   = (focal_x_r == '0) ? CFG_W'(1) : focal_x_r;
  assign focal_y_eff   = (focal_y_r == '0) ? CFG_W'(1) : focal_y_r;
  assign den_x_nxt     = scale_eff_nxt * focal_x_eff;
  assign den_y_nxt     = scale_eff_nxt * focal_y_eff;

  always_ff @(posedge clk) begin
    scale_eff_r <= scale_eff_nxt;
    den_x_r     <= den_x_nxt;
    den_y_r     <= den_y_nxt;
  end

  // Pipeline control.
  logic       adv;
  logic       out_valid_r;
  dpbp_out_t  out_data_r;

  assign adv       = ~out_valid_r | ~out_stall;
  assign in_stall  = ~adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input register.
  logic     in_valid_r;
  dpbp_in_t in_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_valid & (in_data.depth_raw != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_data_r <= in_data;
    end
  end

  // Offset from the principal point, as sign and magnitude.
  mag_stage_t       mag_r;
  mag_stage_t       mag_nxt;
  logic [MAG_W-1:0] pos_x;
  logic [MAG_W-1:0] pos_y;
  logic [MAG_W-1:0] cen_x;
  logic [MAG_W-1:0] cen_y;

  assign pos_x = MAG_W'({in_data_r.pixel_col, 8'h00});
  assign pos_y = MAG_W'({in_data_r.pixel_row, 8'h00});
  assign cen_x = MAG_W'(center_x_r);
  assign cen_y = MAG_W'(center_y_r);

  always_comb begin
    mag_nxt.valid = in_valid_r;
    mag_nxt.depth = in_data_r.depth_raw;
    mag_nxt.neg_x = pos_x < cen_x;
    mag_nxt.mag_x = mag_nxt.neg_x ? (cen_x - pos_x) : (pos_x - cen_x);
    mag_nxt.neg_y = pos_y < cen_y;
    mag_nxt.mag_y = mag_nxt.neg_y ? (cen_y - pos_y) : (pos_y - cen_y);
    mag_nxt.color = '{blue: in_data_r.blue_in, green: in_data_r.green_in,
                      red: in_data_r.red_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r.valid <= 1'b0;
    end else if (adv) begin
      mag_r <= mag_nxt;
    end
  end

  // Offset times depth.
  prod_stage_t prod_r;
  prod_stage_t prod_nxt;

  always_comb begin
    prod_nxt.valid  = mag_r.valid;
    prod_nxt.depth  = mag_r.depth;
    prod_nxt.prod_x = mag_r.mag_x * mag_r.depth;
    prod_nxt.neg_x  = mag_r.neg_x;
    prod_nxt.prod_y = mag_r.mag_y * mag_r.depth;
    prod_nxt.neg_y  = mag_r.neg_y;
    prod_nxt.color  = mag_r.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.valid <= 1'b0;
    end else if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  // Divider setup: the numerator is the product shifted up by the fraction width.
  // Its high part must stay below the divisor, or the quotient leaves 32 bits.
  div_stage_t       div_r [DIV_STEPS+1];
  div_stage_t       div_nxt [DIV_STEPS+1];
  logic [DEN_W-1:0] hi_x;
  logic [DEN_W-1:0] hi_y;

  assign hi_x = DEN_W'(prod_r.prod_x[PROD_W-1:FRAC_BITS]);
  assign hi_y = DEN_W'(prod_r.prod_y[PROD_W-1:FRAC_BITS]);

  always_comb begin
    div_nxt[0].valid  = prod_r.valid;
    div_nxt[0].rem_x  = hi_x;
    div_nxt[0].word_x = {prod_r.prod_x[FRAC_BITS-1:0], {(Q_W-FRAC_BITS){1'b0}}};
    div_nxt[0].neg_x  = prod_r.neg_x;
    div_nxt[0].ovf_x  = hi_x >= den_x_r;
    div_nxt[0].rem_y  = hi_y;
    div_nxt[0].word_y = {prod_r.prod_y[FRAC_BITS-1:0], {(Q_W-FRAC_BITS){1'b0}}};
    div_nxt[0].neg_y  = prod_r.neg_y;
    div_nxt[0].ovf_y  = hi_y >= den_y_r;
    div_nxt[0].rem_z  = '0;
    div_nxt[0].word_z = {prod_r.depth, {(Q_W-DEPTH_W){1'b0}}};
    div_nxt[0].color  = prod_r.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r[0].valid <= 1'b0;
    end else if (adv) begin
      div_r[0] <= div_nxt[0];
    end
  end

  // One quotient bit per stage; quotient bits shift in as numerator bits shift out.
  for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div
    logic [DEN_W:0]   trial_x;
    logic [DEN_W:0]   trial_y;
    logic [SCALE_W:0] trial_z;
    logic             q_x;
    logic             q_y;
    logic             q_z;
    logic [DEN_W:0]   diff_x;
    logic [DEN_W:0]   diff_y;
    logic [SCALE_W:0] diff_z;

    always_comb begin
      trial_x = {div_r[gi].rem_x, div_r[gi].word_x[Q_W-1]};
      trial_y = {div_r[gi].rem_y, div_r[gi].word_y[Q_W-1]};
      trial_z = {div_r[gi].rem_z, div_r[gi].word_z[Q_W-1]};
      diff_x  = trial_x - {1'b0, den_x_r};
      diff_y  = trial_y - {1'b0, den_y_r};
      diff_z  = trial_z - {1'b0, scale_eff_r};
      q_x     = trial_x >= {1'b0, den_x_r};
      q_y     = trial_y >= {1'b0, den_y_r};
      q_z     = trial_z >= {1'b0, scale_eff_r};

      div_nxt[gi+1]        = div_r[gi];
      div_nxt[gi+1].rem_x  = q_x ? diff_x[DEN_W-1:0] : trial_x[DEN_W-1:0];
      div_nxt[gi+1].rem_y  = q_y ? diff_y[DEN_W-1:0] : trial_y[DEN_W-1:0];
      div_nxt[gi+1].rem_z  = q_z ? diff_z[SCALE_W-1:0] : trial_z[SCALE_W-1:0];
      div_nxt[gi+1].word_x = {div_r[gi].word_x[Q_W-2:0], q_x};
      div_nxt[gi+1].word_y = {div_r[gi].word_y[Q_W-2:0], q_y};
      div_nxt[gi+1].word_z = {div_r[gi].word_z[Q_W-2:0], q_z};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[gi+1].valid <= 1'b0;
      end else if (adv) begin
        div_r[gi+1] <= div_nxt[gi+1];
      end
    end
  end

  // Sign, saturation and the output register.
  dpbp_out_t  out_nxt;
  div_stage_t fin;

  assign fin = div_r[DIV_STEPS];

  always_comb begin
    if (fin.neg_x) begin
      out_nxt.point_x = (fin.ovf_x | fin.word_x[Q_W-1]) ? Q_NEG_MIN : (Q_W'(0) - fin.word_x);
    end else begin
      out_nxt.point_x = (fin.ovf_x | fin.word_x[Q_W-1]) ? Q_POS_MAX : fin.word_x;
    end
    if (fin.neg_y) begin
      out_nxt.point_y = (fin.ovf_y | fin.word_y[Q_W-1]) ? Q_NEG_MIN : (Q_W'(0) - fin.word_y);
    end else begin
      out_nxt.point_y = (fin.ovf_y | fin.word_y[Q_W-1]) ? Q_POS_MAX : fin.word_y;
    end
    out_nxt.point_z   = fin.word_z[Q_W-1] ? Z_MAX : fin.word_z[Q_W-2:0];
    out_nxt.blue_out  = fin.color.blue;
    out_nxt.green_out = fin.color.green;
    out_nxt.red_out   = fin.color.red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

@@ design/dpbp_checker.sv @@
// Port-level checker of the depth pixel back-projection block, bound to the top level.
// Depends on dpbp_pkg and on the assertion macros header.
`include "depth_pixel_back_projection_macros.svh"

module dpbp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input dpbp_pkg::dpbp_out_t         out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pready
);
  import dpbp_pkg::*;

  // A stalled result stays valid and unchanged.
  `DPBP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // Requests are held back only while a result waits at the output.
  `DPBP_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")

  // A nonzero depth over a 16-bit scale always gives a nonzero z.
  `DPBP_ASSERT_NOW(a_z_nonzero, clk, rst_n, out_valid, out_data.point_z != '0, "result with zero depth coordinate")

  // The register port never inserts wait states.
  `DPBP_ASSERT_NOW(a_pready, clk, rst_n, psel && penable, pready, "register access not ready")

endmodule

bind depth_pixel_back_projection dpbp_checker u_dpbp_checker (.*);

@@ tb/dpbp_point_checker.sv @@
// Checker for the depth pixel back-projection block: tracks the register file,
// predicts each point from accepted pixel requests and compares results in order.
// Depends on dpbp_pkg for widths, register indexes and the request types.
`timescale 1ns / 100ps

module dpbp_point_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  dpbp_pkg::dpbp_in_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  dpbp_pkg::dpbp_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [dpbp_pkg::ADDR_W-1:0] paddr,
  input  logic [dpbp_pkg::DATA_W-1:0] pwdata,
  input  logic [dpbp_pkg::DATA_W-1:0] prdata,
  output int                          mismatch_count,
  output int                          pending_count,
  output int                          points_seen,
  output int                          bubbles_seen
);
  import dpbp_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [CFG_W-1:0]   focal_x_q;
  logic [CFG_W-1:0]   focal_y_q;
  logic [CFG_W-1:0]   center_x_q;
  logic [CFG_W-1:0]   center_y_q;
  logic [SCALE_W-1:0] scale_q;

  dpbp_out_t expected_points[$];

  function automatic logic [63:0] at_least_one(input logic [63:0] v);
    return (v == 64'd0) ? 64'd1 : v;
  endfunction

  function automatic logic [Q_W-1:0] axis_coord(input logic [COORD_BITS-1:0] pos,
                                               input logic [CFG_W-1:0] center,
                                               input logic [DEPTH_W-1:0] depth,
                                               input logic [63:0] divisor);
    logic [63:0] pos_q8;
    logic [63:0] ctr;
    logic [63:0] mag;
    logic [63:0] quot;
    logic        neg;
    pos_q8 = 64'(pos) << 8;
    ctr    = 64'(center);
    neg    = pos_q8 < ctr;
    mag    = neg ? ctr - pos_q8 : pos_q8 - ctr;
    quot   = ((mag * 64'(depth)) << 16) / divisor;
    if (!neg) begin
      return (quot > 64'(Q_POS_MAX)) ? Q_POS_MAX : quot[Q_W-1:0];
    end
    if (quot > 64'(Q_NEG_MIN)) begin
      quot = 64'(Q_NEG_MIN);
    end
    return 32'd0 - quot[Q_W-1:0];
  endfunction

  function automatic dpbp_out_t project_pixel(input dpbp_in_t px);
    dpbp_out_t   pt;
    logic [63:0] scale_div;
    logic [63:0] z;
    scale_div    = at_least_one(64'(scale_q));
    z            = (64'(px.depth_raw) << 16) / scale_div;
    if (z > 64'(Z_MAX)) begin
      z = 64'(Z_MAX);
    end
    pt.point_x   = axis_coord(px.pixel_col, center_x_q, px.depth_raw,
                              scale_div * at_least_one(64'(focal_x_q)));
    pt.point_y   = axis_coord(px.pixel_row, center_y_q, px.depth_raw,
                              scale_div * at_least_one(64'(focal_y_q)));
    pt.point_z   = z[Q_W-2:0];
    pt.blue_out  = px.blue_in;
    pt.green_out = px.green_in;
    pt.red_out   = px.red_in;
    return pt;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin : watch
    dpbp_out_t         want;
    logic [DATA_W-1:0] shadow;
    if (!rst_n) begin
      focal_x_q  <= FOCAL_X_RST;
      focal_y_q  <= FOCAL_Y_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      scale_q    <= DEPTH_SCALE_RST;
      expected_points.delete();
      pending_count <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_FOCAL_X:     focal_x_q  <= pwdata[CFG_W-1:0];
            REG_FOCAL_Y:     focal_y_q  <= pwdata[CFG_W-1:0];
            REG_CENTER_X:    center_x_q <= pwdata[CFG_W-1:0];
            REG_CENTER_Y:    center_y_q <= pwdata[CFG_W-1:0];
            REG_DEPTH_SCALE: scale_q    <= pwdata[SCALE_W-1:0];
            default: ;
          endcase
        end else if (paddr[ADDR_W-1:2] <= REG_DEPTH_SCALE) begin
          case (paddr[ADDR_W-1:2])
            REG_FOCAL_X:  shadow = DATA_W'(focal_x_q);
            REG_FOCAL_Y:  shadow = DATA_W'(focal_y_q);
            REG_CENTER_X: shadow = DATA_W'(center_x_q);
            REG_CENTER_Y: shadow = DATA_W'(center_y_q);
            default:      shadow = DATA_W'(scale_q);
          endcase
          if (prdata !== shadow) begin
            note_failure($sformatf("register read at %h: expected %h, got %h",
                                   paddr, shadow, prdata));
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (in_data.depth_raw == '0) begin
          bubbles_seen <= bubbles_seen + 1;
        end else begin
          expected_points = {expected_points, project_pixel(in_data)};
        end
      end

      if (out_valid && !out_stall) begin
        points_seen <= points_seen + 1;
        if (expected_points.size() == 0) begin
          note_failure($sformatf("unexpected point x %h y %h z %h", out_data.point_x,
                                 out_data.point_y, out_data.point_z));
        end else begin
          want = expected_points.pop_front();
          if (out_data.point_x !== want.point_x || out_data.point_y !== want.point_y ||
              out_data.point_z !== want.point_z || out_data.blue_out !== want.blue_out ||
              out_data.green_out !== want.green_out || out_data.red_out !== want.red_out) begin
            note_failure($sformatf({"point mismatch: expected x %h y %h z %h bgr %h %h %h,",
                                    " got x %h y %h z %h bgr %h %h %h"},
                                   want.point_x, want.point_y, want.point_z,
                                   want.blue_out, want.green_out, want.red_out,
                                   out_data.point_x, out_data.point_y, out_data.point_z,
                                   out_data.blue_out, out_data.green_out,
                                   out_data.red_out));
          end
        end
      end

      pending_count <= expected_points.size();
    end
  end

endmodule

@@ tb/depth_pixel_back_projection_tb.sv @@
// Testbench top for the depth pixel back-projection block: clock, reset, register
// setup over the APB port, pixel stimulus and the verdict; checking is in dpbp_point_checker.
// Depends on dpbp_pkg, depth_pixel_back_projection and dpbp_point_checker.
`timescale 1ns / 100ps

module depth_pixel_back_projection_tb;
  import dpbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int RANDOM_PHASES  = 6;
  localparam int POINTS_PER_PHASE = 205;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  dpbp_in_t          in_data   = '0;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;

  logic              in_stall;
  logic              out_valid;
  dpbp_out_t         out_data;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic steady = 1'b0;
  int   mismatch_count;
  int   pending_count;
  int   points_seen;
  int   bubbles_seen;
  int   quiet_cycles = 0;
  int   requests_sent = 0;
  int   settings_loaded = 0;

  always #6 clk = ~clk;

  depth_pixel_back_projection u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  dpbp_point_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .points_seen    (points_seen),
    .bubbles_seen   (bubbles_seen)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] fx, input logic [CFG_W-1:0] fy,
                               input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                               input logic [SCALE_W-1:0] scale);
    logic [REG_IDX_W-1:0] idx;
    apb_access(1'b1, REG_FOCAL_X, DATA_W'(fx));
    apb_access(1'b1, REG_FOCAL_Y, DATA_W'(fy));
    apb_access(1'b1, REG_CENTER_X, DATA_W'(cx));
    apb_access(1'b1, REG_CENTER_Y, DATA_W'(cy));
    apb_access(1'b1, REG_DEPTH_SCALE, DATA_W'(scale));
    // A write to an unmapped index must leave every register alone.
    idx = REG_UNUSED_FIRST + REG_IDX_W'($urandom_range(0, 2));
    apb_access(1'b1, idx, DATA_W'($urandom));
    for (int i = 0; i <= REG_DEPTH_SCALE; i++) begin
      apb_access(1'b0, REG_IDX_W'(i), '0);
    end
    settings_loaded++;
  endtask

  task automatic random_settings();
    if ($urandom_range(0, 1) == 0) begin
      load_settings(CFG_W'($urandom_range(20000, 400000)),
                    CFG_W'($urandom_range(20000, 400000)),
                    CFG_W'($urandom_range(0, 1048575)), CFG_W'($urandom_range(0, 1048575)),
                    SCALE_W'($urandom_range(100, 10000)));
    end else begin
      load_settings(($urandom_range(0, 19) == 0) ? 20'd0 : CFG_W'($urandom_range(1, 1048575)),
                    CFG_W'($urandom_range(1, 1048575)),
                    CFG_W'($urandom_range(0, 1048575)), CFG_W'($urandom_range(0, 1048575)),
                    ($urandom_range(0, 19) == 0) ? 16'd0 : SCALE_W'($urandom_range(1, 65535)));
    end
  endtask

  task automatic send_pixel(input dpbp_in_t px);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic dpbp_in_t make_pixel(input logic [DEPTH_W-1:0] depth,
                                          input logic [COORD_BITS-1:0] row,
                                          input logic [COORD_BITS-1:0] col,
                                          input logic [COLOR_W-1:0] b,
                                          input logic [COLOR_W-1:0] g,
                                          input logic [COLOR_W-1:0] r);
    dpbp_in_t px;
    px.depth_raw = depth;
    px.pixel_row = row;
    px.pixel_col = col;
    px.blue_in   = b;
    px.green_in  = g;
    px.red_in    = r;
    return px;
  endfunction

  function automatic logic [COORD_BITS-1:0] random_coord();
    if ($urandom_range(0, 9) == 0) begin
      return ($urandom_range(0, 1) == 0) ? '0 : '1;
    end
    return COORD_BITS'($urandom_range(0, 4095));
  endfunction

  function automatic dpbp_in_t random_pixel();
    dpbp_in_t px;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      px.depth_raw = '0;
    end else if (pick < 13) begin
      px.depth_raw = '1;
    end else if (pick < 20) begin
      px.depth_raw = DEPTH_W'($urandom_range(1, 15));
    end else begin
      px.depth_raw = DEPTH_W'($urandom_range(1, 65535));
    end
    px.pixel_row = random_coord();
    px.pixel_col = random_coord();
    px.blue_in   = COLOR_W'($urandom);
    px.green_in  = COLOR_W'($urandom);
    px.red_in    = COLOR_W'($urandom);
    return px;
  endfunction

  initial begin
    dpbp_in_t px;
    int       sent_points;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(make_pixel(16'd0, 12'd100, 12'd100, 8'd1, 8'd2, 8'd3));
    send_pixel(make_pixel(16'd1, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(16'hFFFF, 12'd0, 12'd0, 8'hFF, 8'h00, 8'h80));
    send_pixel(make_pixel(16'd1, 12'hFFF, 12'd0, 8'h00, 8'hFF, 8'h00));
    send_pixel(make_pixel(16'd1000, 12'd240, 12'd320, 8'h11, 8'h22, 8'h33));
    send_pixel(make_pixel(16'd0, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(16'd40000, 12'd1, 12'd4094, 8'h55, 8'hAA, 8'h55));
    drain();

    // Smallest divisors with the center at opposite corners drive every saturation.
    load_settings(20'd1, 20'd1, 20'd0, 20'hFFFFF, 16'd1);
    send_pixel(make_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 8'h12, 8'h34, 8'h56));
    send_pixel(make_pixel(16'd1, 12'd0, 12'd0, 8'h9A, 8'hBC, 8'hDE));
    send_pixel(make_pixel(16'd1, 12'hFFF, 12'hFFF, 8'h01, 8'h80, 8'hFE));
    send_pixel(make_pixel(16'd0, 12'd7, 12'd9, 8'h00, 8'h00, 8'h00));
    drain();

    // Registers holding zero divide as if they held one.
    load_settings(20'd0, 20'd0, 20'hFFFFF, 20'd0, 16'd0);
    send_pixel(make_pixel(16'hFFFF, 12'hFFF, 12'd0, 8'h7F, 8'h80, 8'h01));
    send_pixel(make_pixel(16'd2, 12'd0, 12'hFFF, 8'hC3, 8'h3C, 8'h5A));
    send_pixel(make_pixel(16'd0, 12'h800, 12'h800, 8'hFF, 8'h00, 8'hFF));
    drain();

    load_settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_pixel(make_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 8'hA5, 8'h5A, 8'hA5));
    send_pixel(make_pixel(16'd1, 12'd0, 12'd0, 8'h0F, 8'hF0, 8'h0F));
    send_pixel(make_pixel(16'hFFFF, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'h00));
    drain();

    // A pixel exactly on the principal point projects to zero lateral offset.
    load_settings(20'd132710, 20'd100000, 20'(100 * 256), 20'(200 * 256), 16'd1000);
    send_pixel(make_pixel(16'd5000, 12'd200, 12'd100, 8'h10, 8'h20, 8'h30));
    send_pixel(make_pixel(16'd5000, 12'd199, 12'd101, 8'h40, 8'h50, 8'h60));
    send_pixel(make_pixel(16'd5000, 12'd201, 12'd99, 8'h70, 8'h80, 8'h90));
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_settings();
      steady      = (phase == 2);
      sent_points = 0;
      while (sent_points < POINTS_PER_PHASE) begin
        px = random_pixel();
        send_pixel(px);
        if (px.depth_raw != '0) begin
          sent_points++;
        end
      end
      drain();
      steady = 1'b0;
    end

    $display("Run covered %0d register settings and %0d pixel requests:", settings_loaded,
             requests_sent);
    $display("%0d points checked, %0d pixels without depth.", points_seen, bubbles_seen);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/dpbp_pkg.sv
design/depth_pixel_back_projection.sv
design/dpbp_checker.sv
tb/dpbp_point_checker.sv
tb/depth_pixel_back_projection_tb.sv
